@@ sv/gar_pkg.sv @@
package gar_pkg;

  localparam logic [1:0] REQ_XSEC    = 2'd0;
  localparam logic [1:0] REQ_SUN     = 2'd1;
  localparam logic [1:0] REQ_COLUMN  = 2'd2;
  localparam logic [1:0] REQ_COMPUTE = 2'd3;

  // log2(e) in Q.16 and 1/pi in Q0.30
  localparam logic [16:0] LOG2E_Q16  = 17'd94548;
  localparam logic [28:0] INV_PI_Q30 = 29'd341782638;
  // 12 in Q.32: beyond it the transmission is zero
  localparam logic [51:0] X_LIMIT    = 52'd12 << 32;

  // 2^(-k/8) in Q.16
  function automatic logic [16:0] pow2_frac(input logic [3:0] k);
    logic [16:0] v;
    case (k)
      4'd0: v = 17'd65536;
      4'd1: v = 17'd60097;
      4'd2: v = 17'd55109;
      4'd3: v = 17'd50535;
      4'd4: v = 17'd46341;
      4'd5: v = 17'd42495;
      4'd6: v = 17'd38968;
      4'd7: v = 17'd35734;
      4'd8: v = 17'd32768;
      default: v = 17'd32768;
    endcase
    return v;
  endfunction

endpackage

@@ sv/gas_absorption_radiance_unit.sv @@
// Loads (cross-sections, sun value, layer columns) leave the input open for the next request.
// A compute transaction runs two inverse-cosine divides of 31 steps beside a sweep reading one
// layer of all gases per cycle; a transmission found zero early skips up to 3 exponent states.
// Input reopens when the result moves into the output register.
// Invalid computes (zero cosine, negative sun cosine, index out of range) give zero radiance.
// Reset (rst, synchronous) clears control only; memories are undefined until written.
module gas_absorption_radiance_unit #(
  parameter int N_SPEC   = 1024,
  parameter int N_LAYERS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [9:0]         spec_index,
  input  logic [4:0]         layer_index,
  input  logic [31:0]        co2_value,
  input  logic [31:0]        ch4_value,
  input  logic [31:0]        h2o_value,
  input  logic [31:0]        sun_value,
  input  logic signed [15:0] mu_sun,
  input  logic signed [15:0] mu_view,
  input  logic [15:0]        albedo,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [31:0]        radiance,
  output logic [9:0]         out_spec_index
);
  import gar_pkg::*;

  localparam int XDEPTH = N_SPEC * N_LAYERS;
  localparam int XA = (XDEPTH > 1) ? $clog2(XDEPTH) : 1;
  localparam int SA = (N_SPEC > 1) ? $clog2(N_SPEC) : 1;
  localparam int LA = (N_LAYERS > 1) ? $clog2(N_LAYERS) : 1;
  localparam int LC = $clog2(N_LAYERS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ACC   = 4'd1;
  localparam logic [3:0] S_DRAIN = 4'd2;
  localparam logic [3:0] S_DIVW  = 4'd3;
  localparam logic [3:0] S_EXP0  = 4'd4;
  localparam logic [3:0] S_EXP1  = 4'd5;
  localparam logic [3:0] S_EXP2  = 4'd6;
  localparam logic [3:0] S_EXP3  = 4'd7;
  localparam logic [3:0] S_RAD0  = 4'd8;
  localparam logic [3:0] S_RAD1  = 4'd9;
  localparam logic [3:0] S_RAD2  = 4'd10;
  localparam logic [3:0] S_RAD3  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  // Memories: three gases share one word, {h2o, ch4, co2}
  logic [95:0] xs_mem  [XDEPTH];
  logic [95:0] col_mem [N_LAYERS];
  logic [31:0] sun_mem [N_SPEC];

  logic [3:0]  state;
  logic        accept;
  logic        spec_ok, layer_ok;
  logic [XA-1:0] xw_addr;

  // Compute context
  logic [9:0]  spec_r;
  logic [14:0] ms_r;
  logic [15:0] alb_r;
  logic [XA-1:0] base_r;
  logic [LC-1:0] lcnt;
  logic [31:0] sun_q;
  logic [95:0] xs_q, col_q;
  logic        v1, v2;
  logic [63:0] p0, p1, p2;
  logic [71:0] acc;
  logic [31:0] am_r;
  logic [51:0] prod_r;
  logic [36:0] y_r;
  logic [4:0]  n_r;
  logic [3:0]  k_r;
  logic [25:0] dr_r;
  logic [15:0] trans_r;
  logic [32:0] a_r;
  logic [31:0] res_r;

  // Divider handshake
  logic        div_start;
  logic [15:0] mv_abs;
  logic        ds_done, dv_done;
  logic [30:0] q_sun, q_view;

  // Datapath products
  logic [20:0] yv;
  logic [3:0]  k_v;
  logic [16:0] t_k, v_frac;
  logic [16:0] v_sh;
  logic [46:0] m0;
  logic [48:0] m1, m2;
  logic [61:0] m3;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign spec_ok  = {7'd0, spec_index} < 17'(N_SPEC);
  assign layer_ok = {4'd0, layer_index} < 9'(N_LAYERS);
  assign xw_addr  = XA'(spec_index * N_LAYERS) + XA'(layer_index);
  assign mv_abs   = mu_view[15] ? 16'(-mu_view) : mu_view;

  // Start the divides only for a request that goes the full path
  assign div_start = accept && req_type == REQ_COMPUTE && spec_ok &&
                     !mu_sun[15] && mu_sun != 16'sd0 && mu_view != 16'sd0;

  gar_div u_div_sun (
    .clk(clk), .rst(rst), .start(div_start), .divisor(mu_sun),
    .done(ds_done), .quotient(q_sun)
  );

  gar_div u_div_view (
    .clk(clk), .rst(rst), .start(div_start), .divisor(mv_abs),
    .done(dv_done), .quotient(q_view)
  );

  // Load writes land in the accept cycle; no compute is in flight then
  always_ff @(posedge clk) begin
    if (accept && req_type == REQ_XSEC && spec_ok && layer_ok)
      xs_mem[xw_addr] <= {h2o_value, ch4_value, co2_value};
    if (accept && req_type == REQ_COLUMN && layer_ok)
      col_mem[LA'(layer_index)] <= {h2o_value, ch4_value, co2_value};
    if (accept && req_type == REQ_SUN && spec_ok)
      sun_mem[SA'(spec_index)] <= sun_value;
  end

  // Registered reads
  always_ff @(posedge clk) begin
    if (div_start)
      sun_q <= sun_mem[SA'(spec_index)];
    if (state == S_ACC) begin
      xs_q  <= xs_mem[base_r + XA'(lcnt)];
      col_q <= col_mem[lcnt[LA-1:0]];
    end
  end

  // Layer sweep: read, multiply, accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == S_ACC);
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1) begin
      p0 <= 64'(xs_q[31:0])  * 64'(col_q[31:0]);
      p1 <= 64'(xs_q[63:32]) * 64'(col_q[63:32]);
      p2 <= 64'(xs_q[95:64]) * 64'(col_q[95:64]);
    end
    if (div_start)
      acc <= 72'd0;
    else if (v2)
      acc <= acc + 72'(p0) + 72'(p1) + 72'(p2);
  end

  // Transmission and radiance arithmetic
  assign yv     = y_r[36:16];
  assign k_v    = {1'b0, yv[15:13]};
  assign t_k    = pow2_frac(k_r);
  assign v_frac = t_k - 17'(dr_r >> 13);
  assign v_sh   = v_frac >> n_r;
  assign m0     = 47'(sun_q) * 47'(ms_r);
  assign m1     = 49'(a_r) * 49'(alb_r);
  assign m2     = 49'(a_r) * 49'(trans_r);
  assign m3     = 62'(a_r) * 62'(INV_PI_Q30);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (div_start)
            state <= S_ACC;
          else if (accept && req_type == REQ_COMPUTE)
            state <= S_OUT;
        end
        S_ACC: begin
          if (lcnt == LC'(N_LAYERS - 1))
            state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (!v1 && !v2)
            state <= S_DIVW;
        end
        S_DIVW: begin
          if (ds_done && dv_done)
            state <= S_EXP0;
        end
        S_EXP0: begin
          state <= (|acc[71:52]) ? S_RAD0 : S_EXP1;
        end
        S_EXP1: begin
          state <= (prod_r > X_LIMIT) ? S_RAD0 : S_EXP2;
        end
        S_EXP2: begin
          state <= (yv[20:16] >= 5'd17) ? S_RAD0 : S_EXP3;
        end
        S_EXP3:  state <= S_RAD0;
        S_RAD0:  state <= S_RAD1;
        S_RAD1:  state <= S_RAD2;
        S_RAD2:  state <= S_RAD3;
        S_RAD3:  state <= S_OUT;
        S_OUT: begin
          if (!out_valid || !out_stall)
            state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept) begin
          spec_r <= spec_index;
          ms_r   <= mu_sun[14:0];
          alb_r  <= albedo;
          base_r <= XA'(spec_index * N_LAYERS);
          lcnt   <= '0;
          res_r  <= 32'd0;
        end
      end
      S_ACC: begin
        lcnt <= lcnt + LC'(1);
      end
      S_DIVW: begin
        am_r <= 32'(q_sun) + 32'(q_view);
      end
      S_EXP0: begin
        // tau of 2^20 or more exceeds the limit for any airmass
        if (|acc[71:52])
          trans_r <= 16'd0;
        prod_r <= 52'(acc[51:32]) * 52'(am_r);
      end
      S_EXP1: begin
        if (prod_r > X_LIMIT)
          trans_r <= 16'd0;
        y_r <= 37'(prod_r[35:16]) * 37'(LOG2E_Q16);
      end
      S_EXP2: begin
        if (yv[20:16] >= 5'd17)
          trans_r <= 16'd0;
        n_r  <= yv[20:16];
        k_r  <= k_v;
        dr_r <= 26'(pow2_frac(k_v) - pow2_frac(4'(k_v + 4'd1))) * 26'(yv[12:0]);
      end
      S_EXP3: begin
        trans_r <= v_sh[16] ? 16'hFFFF : v_sh[15:0];
      end
      S_RAD0: a_r <= m0[46:14];
      S_RAD1: a_r <= m1[48:16];
      S_RAD2: a_r <= m2[48:16];
      S_RAD3: res_r <= m3[61:30];
      default: ;
    endcase
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && (!out_valid || !out_stall)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!out_valid || !out_stall)) begin
      radiance       <= res_r;
      out_spec_index <= spec_r;
    end
  end

endmodule

@@ sv/gar_div.sv @@
// Restoring divider: quotient of 2^30 by a 16-bit divisor, one bit per cycle.
module gar_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [30:0] quotient
);
  logic [15:0] d;
  logic [15:0] rem;
  logic [4:0]  cnt;
  logic        busy;
  logic [16:0] rem_sh;
  logic        ge;

  // the dividend is a single one at bit 30
  assign rem_sh = {rem, (cnt == 5'd30)};
  assign ge     = rem_sh >= {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && cnt == 5'd0) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      d        <= divisor;
      rem      <= 16'd0;
      cnt      <= 5'd30;
      quotient <= 31'd0;
    end else if (busy) begin
      rem      <= ge ? 16'(rem_sh - {1'b0, d}) : rem_sh[15:0];
      quotient <= {quotient[29:0], ge};
      cnt      <= cnt - 5'd1;
    end
  end

endmodule

@@ sv/gar_check.sv @@
module gar_check #(
  parameter int N_SPEC = 1024
) (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  req_type,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] radiance,
  input logic [9:0]  out_spec_index
);
  import gar_pkg::*;

  // a load never stalls the input
  a_load_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type != REQ_COMPUTE |=> !in_stall)
    else $error("busy after load");

  a_compute_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && req_type == REQ_COMPUTE |=> in_stall)
    else $error("not busy after compute");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(radiance) && $stable(out_spec_index))
    else $error("output changed while stalled");

  a_bad_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && ({7'd0, out_spec_index} >= 17'(N_SPEC)) |-> radiance == 32'd0)
    else $error("nonzero radiance for out-of-range index");

endmodule

bind gas_absorption_radiance_unit gar_check #(.N_SPEC(N_SPEC)) u_gar_check (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .req_type(req_type), .out_valid(out_valid), .out_stall(out_stall),
  .radiance(radiance), .out_spec_index(out_spec_index)
);
